// ===== rtl/rv32i_eu_pkg.sv =====
// Shared types, operation codes and constants for the RV32I execute unit.
package rv32i_eu_pkg;

   localparam int unsigned XLEN       = 32;
   localparam int unsigned OP_BITS    = 6;
   localparam int unsigned SHAMT_BITS = 5;

   localparam logic [XLEN-1:0] PC_STEP   = 32'd4;
   localparam logic [XLEN-1:0] JALR_MASK = ~32'd1;

   typedef enum logic [OP_BITS-1:0] {
      OP_LUI   = 6'd0,
      OP_AUIPC = 6'd1,
      OP_JAL   = 6'd2,
      OP_JALR  = 6'd3,
      OP_BEQ   = 6'd4,
      OP_BNE   = 6'd5,
      OP_BLT   = 6'd6,
      OP_BGE   = 6'd7,
      OP_BLTU  = 6'd8,
      OP_BGEU  = 6'd9,
      OP_LB    = 6'd10,
      OP_LH    = 6'd11,
      OP_LW    = 6'd12,
      OP_LBU   = 6'd13,
      OP_LHU   = 6'd14,
      OP_SB    = 6'd15,
      OP_SH    = 6'd16,
      OP_SW    = 6'd17,
      OP_ADDI  = 6'd18,
      OP_SLTI  = 6'd19,
      OP_SLTIU = 6'd20,
      OP_XORI  = 6'd21,
      OP_ORI   = 6'd22,
      OP_ANDI  = 6'd23,
      OP_SLLI  = 6'd24,
      OP_SRAI  = 6'd25,
      OP_SRLI  = 6'd26,
      OP_ADD   = 6'd27,
      OP_SUB   = 6'd28,
      OP_SLL   = 6'd29,
      OP_SLT   = 6'd30,
      OP_SLTU  = 6'd31,
      OP_XOR   = 6'd32,
      OP_OR    = 6'd33,
      OP_AND   = 6'd34,
      OP_SRA   = 6'd35,
      OP_SRL   = 6'd36
   } op_type;

   typedef struct packed {
      logic [OP_BITS-1:0]     operation;
      logic [XLEN-1:0]        pc;
      logic [XLEN-1:0]        src1_value;
      logic [XLEN-1:0]        src2_value;
      logic signed [XLEN-1:0] immediate;
   } req_payload_type;

   typedef struct packed {
      logic [XLEN-1:0] dest_value;
      logic [XLEN-1:0] next_pc;
      logic [XLEN-1:0] mem_address;
      logic            illegal;
   } rsp_payload_type;

endpackage

// ===== rtl/rv32i_eu_req_if.sv =====
// Request channel interface carrying one decoded instruction per transaction.
interface rv32i_eu_req_if
   import rv32i_eu_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [OP_BITS-1:0]     operation;
   logic [XLEN-1:0]        pc;
   logic [XLEN-1:0]        src1_value;
   logic [XLEN-1:0]        src2_value;
   logic signed [XLEN-1:0] immediate;

   modport source (output valid, operation, pc, src1_value, src2_value, immediate,
                   input ready);
   modport sink   (input valid, operation, pc, src1_value, src2_value, immediate,
                   output ready);
endinterface

// ===== rtl/rv32i_eu_rsp_if.sv =====
// Response channel interface carrying one execute result per transaction.
interface rv32i_eu_rsp_if
   import rv32i_eu_pkg::*;
   ();
   logic            valid;
   logic            ready;
   logic [XLEN-1:0] dest_value;
   logic [XLEN-1:0] next_pc;
   logic [XLEN-1:0] mem_address;
   logic            illegal;

   modport source (output valid, dest_value, next_pc, mem_address, illegal,
                   input ready);
   modport sink   (input valid, dest_value, next_pc, mem_address, illegal,
                   output ready);
endinterface

// ===== rtl/rv32i_eu_in_stage.sv =====
// Input register stage that captures request transactions.
module rv32i_eu_in_stage
   import rv32i_eu_pkg::*;
   (
   input  logic            clock,
   input  logic            reset,
   rv32i_eu_req_if.sink    req,
   output logic            out_valid,
   input  logic            out_ready,
   output req_payload_type out_data
   );

   logic            valid_ff;
   logic            valid_in;
   req_payload_type data_ff;
   req_payload_type data_in;
   logic            load;

   assign load      = !valid_ff || out_ready;
   assign req.ready = load;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = req.valid;
         if (req.valid) begin
            data_in.operation  = req.operation;
            data_in.pc         = req.pc;
            data_in.src1_value = req.src1_value;
            data_in.src2_value = req.src2_value;
            data_in.immediate  = req.immediate;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/rv32i_eu_alu.sv =====
// Combinational execute logic: ALU, branch compare and address generation.
module rv32i_eu_alu
   import rv32i_eu_pkg::*;
   (
   input  req_payload_type in_data,
   output rsp_payload_type out_data
   );

   logic [XLEN-1:0]       a;
   logic [XLEN-1:0]       b;
   logic [XLEN-1:0]       imm;
   logic [XLEN-1:0]       pc_seq;
   logic [XLEN-1:0]       pc_target;
   logic [XLEN-1:0]       a_plus_imm;
   logic [SHAMT_BITS-1:0] sh_imm;
   logic [SHAMT_BITS-1:0] sh_reg;
   logic                  lt_ab;
   logic                  ltu_ab;
   logic                  lt_ai;
   logic                  ltu_ai;
   logic                  take;
   op_type                op;

   assign op         = op_type'(in_data.operation);
   assign a          = in_data.src1_value;
   assign b          = in_data.src2_value;
   assign imm        = in_data.immediate;
   assign pc_seq     = in_data.pc + PC_STEP;
   assign pc_target  = in_data.pc + imm;
   assign a_plus_imm = a + imm;
   assign sh_imm     = imm[SHAMT_BITS-1:0];
   assign sh_reg     = b[SHAMT_BITS-1:0];
   assign lt_ab      = $signed(a) < $signed(b);
   assign ltu_ab     = a < b;
   assign lt_ai      = $signed(a) < $signed(imm);
   assign ltu_ai     = a < imm;

   always_comb begin
      case (op)
         OP_BEQ:  take = (a == b);
         OP_BNE:  take = (a != b);
         OP_BLT:  take = lt_ab;
         OP_BGE:  take = !lt_ab;
         OP_BLTU: take = ltu_ab;
         OP_BGEU: take = !ltu_ab;
         default: take = 1'b0;
      endcase
   end

   always_comb begin
      out_data.dest_value  = '0;
      out_data.next_pc     = take ? pc_target : pc_seq;
      out_data.mem_address = '0;
      out_data.illegal     = 1'b0;
      unique case (op) inside
         OP_LUI:   out_data.dest_value = imm;
         OP_AUIPC: out_data.dest_value = pc_target;
         OP_JAL: begin
            out_data.dest_value = pc_seq;
            out_data.next_pc    = pc_target;
         end
         OP_JALR: begin
            out_data.dest_value = pc_seq;
            out_data.next_pc    = a_plus_imm & JALR_MASK;
         end
         OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU: begin
            out_data.dest_value = '0;
         end
         [OP_LB:OP_SW]: out_data.mem_address = a_plus_imm;
         OP_ADDI:  out_data.dest_value = a_plus_imm;
         OP_SLTI:  out_data.dest_value = {{(XLEN-1){1'b0}}, lt_ai};
         OP_SLTIU: out_data.dest_value = {{(XLEN-1){1'b0}}, ltu_ai};
         OP_XORI:  out_data.dest_value = a ^ imm;
         OP_ORI:   out_data.dest_value = a | imm;
         OP_ANDI:  out_data.dest_value = a & imm;
         OP_SLLI:  out_data.dest_value = a << sh_imm;
         OP_SRAI:  out_data.dest_value = $unsigned($signed(a) >>> sh_imm);
         OP_SRLI:  out_data.dest_value = a >> sh_imm;
         OP_ADD:   out_data.dest_value = a + b;
         OP_SUB:   out_data.dest_value = a - b;
         OP_SLL:   out_data.dest_value = a << sh_reg;
         OP_SLT:   out_data.dest_value = {{(XLEN-1){1'b0}}, lt_ab};
         OP_SLTU:  out_data.dest_value = {{(XLEN-1){1'b0}}, ltu_ab};
         OP_XOR:   out_data.dest_value = a ^ b;
         OP_OR:    out_data.dest_value = a | b;
         OP_AND:   out_data.dest_value = a & b;
         OP_SRA:   out_data.dest_value = $unsigned($signed(a) >>> sh_reg);
         OP_SRL:   out_data.dest_value = a >> sh_reg;
         default:  out_data.illegal    = 1'b1;
      endcase
   end

endmodule

// ===== rtl/rv32i_eu_out_stage.sv =====
// Result register stage that drives response transactions.
module rv32i_eu_out_stage
   import rv32i_eu_pkg::*;
   (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  rsp_payload_type in_data,
   rv32i_eu_rsp_if.source  rsp
   );

   logic            valid_ff;
   logic            valid_in;
   rsp_payload_type data_ff;
   rsp_payload_type data_in;
   logic            load;

   assign load     = !valid_ff || rsp.ready;
   assign in_ready = load;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = in_valid;
         if (in_valid) begin
            data_in = in_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp.valid       = valid_ff;
   assign rsp.dest_value  = data_ff.dest_value;
   assign rsp.next_pc     = data_ff.next_pc;
   assign rsp.mem_address = data_ff.mem_address;
   assign rsp.illegal     = data_ff.illegal;

endmodule

// ===== rtl/rv32i_execute_unit.sv =====
// Top level of the RV32I execute unit.
//
// The req channel takes one decoded instruction per transaction: operation
// code, program counter, two source register values and the sign-extended
// immediate. The rsp channel returns one result per transaction: the
// destination register value, the next program counter, the load/store
// address and a flag for an unknown operation code.
// An instruction is captured in an input register, evaluated by one level of
// adder, comparator and shifter logic, and captured in a result register.
// A transaction accepted on req is held in the input register and then in
// the result register, which presents it on rsp. While rsp ready is high,
// one transaction can be accepted in every cycle, for one result per cycle.
// The block holds at most two transactions. When the receiver holds rsp
// ready low, the result stays on rsp and the input register still takes one
// more transaction; req ready then falls until the result is taken.
// Synchronous reset empties both registers; no transaction is lost or
// repeated across a stall.
module rv32i_execute_unit
   import rv32i_eu_pkg::*;
   (
   input  logic           clock,
   input  logic           reset,
   rv32i_eu_req_if.sink   req,
   rv32i_eu_rsp_if.source rsp
   );

   logic            s1_valid;
   logic            s1_ready;
   req_payload_type s1_data;
   rsp_payload_type alu_result;

   rv32i_eu_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   rv32i_eu_alu u_alu (
      .in_data  (s1_data),
      .out_data (alu_result)
   );

   rv32i_eu_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_valid),
      .in_ready (s1_ready),
      .in_data  (alu_result),
      .rsp      (rsp)
   );

endmodule

// ===== rtl/rv32i_eu_checker.sv =====
// Port-level assertions for the RV32I execute unit and their bind statement.
module rv32i_eu_checker
   import rv32i_eu_pkg::*;
   (
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [XLEN-1:0] rsp_dest_value,
   input logic [XLEN-1:0] rsp_mem_address,
   input logic            rsp_illegal
   );

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("Request not ready while the result register is empty.");

   a_illegal_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_illegal |-> rsp_dest_value == '0 && rsp_mem_address == '0)
      else $error("Illegal operation produced a destination value or address.");

   a_mem_no_dest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mem_address != '0 |-> rsp_dest_value == '0 && !rsp_illegal)
      else $error("Memory access result also wrote a destination value.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dest_value))
      else $error("Stalled response transaction changed.");

endmodule

bind rv32i_execute_unit rv32i_eu_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_dest_value  (rsp.dest_value),
   .rsp_mem_address (rsp.mem_address),
   .rsp_illegal     (rsp.illegal)
);

// ===== bench/testbench.sv =====
// Self-checking testbench for the RV32I execute unit, with a directed table and random traffic.
`timescale 1ns / 100ps

module testbench;
   import rv32i_eu_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 950;
   localparam int unsigned HOLD_AT      = 120;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT  = 200000;

   localparam logic [OP_BITS-1:0] ILLEGAL_FIRST = 6'd37;
   localparam logic [OP_BITS-1:0] ILLEGAL_LAST  = 6'd63;

   typedef struct {
      req_payload_type instr;
      bit              typed;
      rsp_payload_type result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rv32i_eu_req_if req_bus ();
   rv32i_eu_rsp_if rsp_bus ();

   rv32i_execute_unit i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   stim_row_type    stim_table [$];
   rsp_payload_type expected_results [$];
   rsp_payload_type oldest_result;
   int unsigned     error_count       = 0;
   int unsigned     cycle_count       = 0;
   int unsigned     sender_idle_pct   = 22;
   int unsigned     receiver_idle_pct = 52;
   bit              long_hold_request = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_payload_type execute_instr(input req_payload_type instr);
      logic [XLEN-1:0] a;
      logic [XLEN-1:0] b;
      logic [XLEN-1:0] imm;
      logic [XLEN-1:0] link;
      logic [XLEN-1:0] target;
      rsp_payload_type r;
      a      = instr.src1_value;
      b      = instr.src2_value;
      imm    = instr.immediate;
      link   = instr.pc + PC_STEP;
      target = instr.pc + imm;
      r.dest_value  = '0;
      r.next_pc     = link;
      r.mem_address = '0;
      r.illegal     = 1'b0;
      case (instr.operation)
         OP_LUI:   r.dest_value = imm;
         OP_AUIPC: r.dest_value = target;
         OP_JAL: begin
            r.dest_value = link;
            r.next_pc    = target;
         end
         OP_JALR: begin
            r.dest_value = link;
            r.next_pc    = (a + imm) & JALR_MASK;
         end
         OP_BEQ:  if (a == b) r.next_pc = target;
         OP_BNE:  if (a != b) r.next_pc = target;
         OP_BLT:  if ($signed(a) < $signed(b)) r.next_pc = target;
         OP_BGE:  if ($signed(a) >= $signed(b)) r.next_pc = target;
         OP_BLTU: if (a < b) r.next_pc = target;
         OP_BGEU: if (a >= b) r.next_pc = target;
         OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW:
            r.mem_address = a + imm;
         OP_ADDI:  r.dest_value = a + imm;
         OP_SLTI:  r.dest_value = {31'd0, $signed(a) < $signed(imm)};
         OP_SLTIU: r.dest_value = {31'd0, a < imm};
         OP_XORI:  r.dest_value = a ^ imm;
         OP_ORI:   r.dest_value = a | imm;
         OP_ANDI:  r.dest_value = a & imm;
         OP_SLLI:  r.dest_value = a << imm[SHAMT_BITS-1:0];
         OP_SRAI:  r.dest_value = $signed(a) >>> imm[SHAMT_BITS-1:0];
         OP_SRLI:  r.dest_value = a >> imm[SHAMT_BITS-1:0];
         OP_ADD:   r.dest_value = a + b;
         OP_SUB:   r.dest_value = a - b;
         OP_SLL:   r.dest_value = a << b[SHAMT_BITS-1:0];
         OP_SLT:   r.dest_value = {31'd0, $signed(a) < $signed(b)};
         OP_SLTU:  r.dest_value = {31'd0, a < b};
         OP_XOR:   r.dest_value = a ^ b;
         OP_OR:    r.dest_value = a | b;
         OP_AND:   r.dest_value = a & b;
         OP_SRA:   r.dest_value = $signed(a) >>> b[SHAMT_BITS-1:0];
         OP_SRL:   r.dest_value = a >> b[SHAMT_BITS-1:0];
         default:  r.illegal = 1'b1;
      endcase
      return r;
   endfunction

   function automatic void table_row(input logic [OP_BITS-1:0] op, input logic [XLEN-1:0] pc,
                                     input logic [XLEN-1:0] a, input logic [XLEN-1:0] b,
                                     input logic [XLEN-1:0] imm, input bit typed,
                                     input logic [XLEN-1:0] dest, input logic [XLEN-1:0] npc,
                                     input logic [XLEN-1:0] addr, input logic ill);
      stim_row_type row;
      row.instr.operation     = op;
      row.instr.pc            = pc;
      row.instr.src1_value    = a;
      row.instr.src2_value    = b;
      row.instr.immediate     = imm;
      row.typed               = typed;
      row.result.dest_value   = dest;
      row.result.next_pc      = npc;
      row.result.mem_address  = addr;
      row.result.illegal      = ill;
      stim_table.push_back(row);
   endfunction

   function automatic logic [XLEN-1:0] pick_operand();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return $urandom_range(0, 40);
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [XLEN-1:0] got,
                                  input logic [XLEN-1:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic offer_instr(input req_payload_type instr, input rsp_payload_type result);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= instr.operation;
      req_bus.pc         <= instr.pc;
      req_bus.src1_value <= instr.src1_value;
      req_bus.src2_value <= instr.src2_value;
      req_bus.immediate  <= instr.immediate;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_results.push_back(result);
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_bus.next_pc, '0);
         end else begin
            oldest_result = expected_results.pop_front();
            if (rsp_bus.dest_value !== oldest_result.dest_value)
               report_mismatch("dest_value", rsp_bus.dest_value, oldest_result.dest_value);
            if (rsp_bus.next_pc !== oldest_result.next_pc)
               report_mismatch("next_pc", rsp_bus.next_pc, oldest_result.next_pc);
            if (rsp_bus.mem_address !== oldest_result.mem_address)
               report_mismatch("mem_address", rsp_bus.mem_address, oldest_result.mem_address);
            if (rsp_bus.illegal !== oldest_result.illegal)
               report_mismatch("illegal", {31'd0, rsp_bus.illegal},
                               {31'd0, oldest_result.illegal});
         end
      end
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            @(posedge clock);
         end
      end
   end

   initial begin
      req_payload_type instr;
      int unsigned     n;
      req_bus.valid      <= 1'b0;
      req_bus.operation  <= '0;
      req_bus.pc         <= '0;
      req_bus.src1_value <= '0;
      req_bus.src2_value <= '0;
      req_bus.immediate  <= '0;

      table_row(OP_LUI,   32'h0, 32'h0, 32'h0, 32'hFFFF_F000, 1, 32'hFFFF_F000, 32'h4, 0, 0);
      table_row(OP_AUIPC, 32'hFFFF_FFFC, 32'h0, 32'h0, 32'h4, 1, 32'h0, 32'h0, 0, 0);
      table_row(OP_JAL,   32'h1000, 32'h0, 32'h0, 32'hFFFF_FFFC, 1, 32'h1004, 32'h0FFC, 0, 0);
      table_row(OP_JALR,  32'h2000, 32'h1001, 32'h0, 32'h0, 1, 32'h2004, 32'h1000, 0, 0);
      table_row(OP_JALR,  32'h0, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
      table_row(OP_BEQ,   32'h100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h40, 1, 32'h0, 32'h140, 0, 0);
      table_row(OP_BNE,   32'h100, 32'h0, 32'h0, 32'h40, 1, 32'h0, 32'h104, 0, 0);
      table_row(OP_BLT,   32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0);
      table_row(OP_BGE,   32'h40, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFF0, 0, 0, 0, 0, 0);
      table_row(OP_BLTU,  32'h80, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
      table_row(OP_BGEU,  32'hFFFF_FFF0, 32'h8000_0000, 32'h8000_0000, 32'h20, 0, 0, 0, 0, 0);
      table_row(OP_LW,    32'h0, 32'hFFFF_FFFF, 32'h0, 32'h1, 1, 32'h0, 32'h4, 32'h0, 0);
      table_row(OP_SB,    32'h10, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0);
      table_row(OP_LHU,   32'h20, 32'h1234_5678, 32'h0, 32'hFFFF_F800, 0, 0, 0, 0, 0);
      table_row(OP_ADDI,  32'h30, 32'h7FFF_FFFF, 32'h0, 32'h1, 0, 0, 0, 0, 0);
      table_row(OP_SLTI,  32'h30, 32'hFFFF_FFFF, 32'h0, 32'h0, 0, 0, 0, 0, 0);
      table_row(OP_SLTIU, 32'h30, 32'h0, 32'h0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
      table_row(OP_SLLI,  32'h30, 32'h1, 32'h0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
      table_row(OP_SRAI,  32'h30, 32'h8000_0000, 32'h0, 32'h1F, 0, 0, 0, 0, 0);
      table_row(OP_SRLI,  32'h30, 32'hFFFF_FFFF, 32'h0, 32'h20, 0, 0, 0, 0, 0);
      table_row(OP_SUB,   32'h30, 32'h0, 32'h1, 32'h0, 0, 0, 0, 0, 0);
      table_row(OP_SLL,   32'h30, 32'hFFFF_FFFF, 32'hFFFF_FFE1, 32'h0, 0, 0, 0, 0, 0);
      table_row(OP_SRA,   32'h30, 32'h7FFF_FFFF, 32'h1F, 32'h0, 0, 0, 0, 0, 0);
      table_row(OP_SLTU,  32'h30, 32'hFFFF_FFFF, 32'h0, 32'h0, 0, 0, 0, 0, 0);
      table_row(ILLEGAL_FIRST, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                32'h0, 32'h4, 32'h0, 1);
      table_row(ILLEGAL_LAST, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                32'h0, 32'h0, 32'h0, 1);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         if (stim_table[i].typed)
            offer_instr(stim_table[i].instr, stim_table[i].result);
         else
            offer_instr(stim_table[i].instr, execute_instr(stim_table[i].instr));
      end

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            sender_idle_pct   = 52;
            receiver_idle_pct = 22;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         if (n == HOLD_AT)
            long_hold_request = 1'b1;
         if ($urandom_range(0, 99) < 88)
            instr.operation = OP_BITS'($urandom_range(OP_LUI, OP_SRL));
         else
            instr.operation = OP_BITS'($urandom_range(ILLEGAL_FIRST, ILLEGAL_LAST));
         instr.pc         = pick_operand();
         instr.src1_value = pick_operand();
         instr.src2_value = ($urandom_range(0, 3) == 0) ? instr.src1_value : pick_operand();
         instr.immediate  = pick_operand();
         offer_instr(instr, execute_instr(instr));
      end
      req_bus.valid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
